>>> sv/wildcard_name_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Wildcard name matcher assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_NAME_MATCHER_TOP_MACROS_SVH
`define WILDCARD_NAME_MATCHER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside of reset
`define WNM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("wildcard_name_matcher: assertion failed");

// Checked on every clock edge, reset included
`define WNM_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("wildcard_name_matcher: assertion failed");

`else

`define WNM_ASSERT(label, prop)
`define WNM_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> sv/wnm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard name matcher package
// Shared constants and types for the star-only name matcher.
// ----------------------------------------------------------------------------
package wnm_pkg;

	// Pattern store geometry
	localparam int STORE_BYTES     = 16;
	localparam int PATTERN_LEN_DEF = 16;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 2;

	// Pattern and name positions
	localparam int POS_W      = 5;
	localparam int NAME_POS_W = 8;

	localparam logic [POS_W-1:0]      POS_MAX       = '1;
	localparam logic [NAME_POS_W-1:0] NAME_POS_MAX  = '1;
	localparam logic [NAME_POS_W-1:0] MAX_LEN_RESET = 8'd255;

	// Byte codes
	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] FOLD_MASK = 8'hDF;
	localparam logic [7:0] NUL_CHAR  = 8'h00;

	// Configuration register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_CASE_SENS    = 2'd2,
		REG_MAX_LEN      = 2'd3
	} cfg_reg_t;

	typedef logic [STORE_BYTES-1:0][7:0] pattern_t;

endpackage

>>> sv/wildcard_name_matcher_top.sv
// ----------------------------------------------------------------------------
// Wildcard name matcher
// Matches a streamed name, one byte per transaction, against a stored pattern
// where '*' sets a single resume point; a zero byte closes the name.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------
//  name in   | in        | in_valid / in_ready  | name_byte [7:0]
//  result    | out       | out_valid / out_ready| matched
//  config    | in        | cfg_we               | cfg_index [1:0], cfg_data [63:0]
//
// One name byte per cycle. A byte is registered into stage 1, where the
// pattern lookup, star handling and compare update the match state in the
// same cycle; a zero byte loads the result register when it leaves stage 1,
// and the result is offered from that register until it is taken.
// The state update loop (pattern position) sets the rate. A zero byte stalls
// in stage 1 only while the result register is full and not being drained;
// other bytes never stall in stage 1, but wait at the input behind a stalled
// zero byte. Reset clears state and loads register reset values at once.
//
`include "wildcard_name_matcher_top_macros.svh"

module wildcard_name_matcher_top #(
	parameter int PATTERN_LEN = wnm_pkg::PATTERN_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            name_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  matched,
	input  logic                                  cfg_we,
	input  logic [wnm_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [wnm_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import wnm_pkg::*;

	// Configuration registers
	pattern_t              pattern_q;
	logic                  case_sens_q;
	logic [NAME_POS_W-1:0] max_len_q;

	// Stage 1 input register
	logic                  valid_s1;
	logic [7:0]            byte_s1;

	// Match state
	logic [POS_W-1:0]      pat_pos_q;
	logic [POS_W-1:0]      star_pos_q;
	logic [NAME_POS_W-1:0] name_pos_q;
	logic                  saw_q;

	// Result register
	logic                  out_valid_q;
	logic                  matched_q;

	// Stage 1 combinational
	logic                  term_s1;
	logic                  advance_s1;
	logic [7:0]            pb_cur;
	logic [7:0]            pb_next;
	logic                  is_star;
	logic [POS_W-1:0]      pat_pos_a;
	logic [POS_W-1:0]      star_pos_a;
	logic [7:0]            cmp_pat;
	logic [7:0]            cmp_name;
	logic                  hit;
	logic [POS_W-1:0]      pat_pos_n;
	logic [NAME_POS_W-1:0] limit;
	logic                  in_range;
	logic                  match_res;

	// Pattern byte at a position; past the store or the length reads as zero
	function automatic logic [7:0] pat_rd(input pattern_t pat, input logic [POS_W-1:0] idx);
		logic [7:0] r;
		r = NUL_CHAR;
		if (int'(idx) < STORE_BYTES && int'(idx) < PATTERN_LEN)
			r = pat[idx[$clog2(STORE_BYTES)-1:0]];
		return r;
	endfunction

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
		return (p == POS_MAX) ? POS_MAX : p + 1'b1;
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= '0;
			case_sens_q <= 1'b0;
			max_len_q   <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pattern_q[STORE_BYTES/2-1:0] <= cfg_data;
				REG_PATTERN_HIGH: pattern_q[STORE_BYTES-1:STORE_BYTES/2] <= cfg_data;
				REG_CASE_SENS:    case_sens_q <= cfg_data[0];
				REG_MAX_LEN:      max_len_q <= cfg_data[NAME_POS_W-1:0];
				default:          ;
			endcase
		end
	end

	// Handshake: a zero byte needs room in the result register
	assign term_s1    = (byte_s1 == NUL_CHAR);
	assign advance_s1 = valid_s1 && (!term_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	// Star handling and compare
	always_comb begin
		pb_cur     = pat_rd(pattern_q, pat_pos_q);
		pb_next    = pat_rd(pattern_q, pos_inc(pat_pos_q));
		is_star    = (pb_cur == STAR_CHAR);
		pat_pos_a  = is_star ? pos_inc(pat_pos_q) : pat_pos_q;
		star_pos_a = is_star ? pat_pos_a : star_pos_q;
		cmp_pat    = is_star ? pb_next : pb_cur;
		cmp_name   = byte_s1;
		if (!case_sens_q) begin
			cmp_pat  = cmp_pat & FOLD_MASK;
			cmp_name = cmp_name & FOLD_MASK;
		end
		hit       = (cmp_pat == cmp_name);
		pat_pos_n = hit ? pos_inc(pat_pos_a) : star_pos_a;
		limit     = (max_len_q == '0) ? NAME_POS_W'(1) : max_len_q;
		in_range  = (name_pos_q < limit);
		match_res = saw_q && (pb_cur == NUL_CHAR);
	end

	// Stage 1 input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= name_byte;
	end

	// Match state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_pos_q  <= '0;
			star_pos_q <= '0;
			name_pos_q <= '0;
			saw_q      <= 1'b0;
		end else if (advance_s1) begin
			if (term_s1) begin
				pat_pos_q  <= '0;
				star_pos_q <= '0;
				name_pos_q <= '0;
				saw_q      <= 1'b0;
			end else if (in_range) begin
				pat_pos_q  <= pat_pos_n;
				star_pos_q <= star_pos_a;
				saw_q      <= 1'b1;
				if (name_pos_q != NAME_POS_MAX)
					name_pos_q <= name_pos_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && term_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && term_s1)
			matched_q <= match_res;
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	// Assertions
	`WNM_ASSERT(a_result_from_term, $rose(out_valid_q) |-> $past(advance_s1 && term_s1))
	`WNM_ASSERT(a_term_clears, (advance_s1 && term_s1) |=> (pat_pos_q == '0 && !saw_q))
	`WNM_ASSERT_ALWAYS(a_resume_behind, star_pos_q <= pat_pos_q)
	`WNM_ASSERT_ALWAYS(a_saw_vs_count, (name_pos_q == '0) == !saw_q)

endmodule

>>> bench/tb_wildcard_name_matcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard name matcher testbench
// Streams names, one byte per transaction, through the matcher under a range
// of pattern, case and length-limit settings. A scoreboard tracks the pattern
// walk of each name and checks every matched result in order.
// ----------------------------------------------------------------------------
module tb_wildcard_name_matcher_top;
	import wnm_pkg::*;

	localparam int RANDOM_ITEMS   = 1750;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 4;

	typedef logic [7:0] byte_q_t[$];

	// Tracks the pattern walk of the current name and the results it owes
	class match_scoreboard;
		pattern_t                pat;
		logic                    case_sens;
		logic [NAME_POS_W-1:0]   max_len;
		logic [POS_W-1:0]        pat_pos;
		logic [POS_W-1:0]        star_pos;
		logic [NAME_POS_W-1:0]   name_pos;
		logic                    seen_byte;
		logic                    expected_matches[$];
		int                      errors;
		int                      bytes_taken;
		int                      bytes_skipped;
		int                      results_checked;
		int                      matches_seen;
		int                      cfg_writes;

		function new();
			pat       = '0;
			case_sens = 1'b0;
			max_len   = MAX_LEN_RESET;
			clear_name();
		endfunction

		function void clear_name();
			pat_pos   = '0;
			star_pos  = '0;
			name_pos  = '0;
			seen_byte = 1'b0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			cfg_writes++;
			case (idx)
				REG_PATTERN_LOW:  pat[7:0]  = data;
				REG_PATTERN_HIGH: pat[15:8] = data;
				REG_CASE_SENS:    case_sens = data[0];
				REG_MAX_LEN:      max_len   = data[7:0];
				default: ;
			endcase
		endfunction

		// Positions past the store read as the terminator
		function logic [7:0] pattern_at(logic [POS_W-1:0] idx);
			if (idx >= STORE_BYTES || idx >= PATTERN_LEN_DEF)
				return NUL_CHAR;
			return pat[idx[3:0]];
		endfunction

		function logic [POS_W-1:0] bump(logic [POS_W-1:0] p);
			return (p == POS_MAX) ? p : p + 1'b1;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [NAME_POS_W-1:0] limit;
			logic [7:0]            c;
			logic [7:0]            nb;
			// End of name: owe one result, start over
			if (b == NUL_CHAR) begin
				expected_matches.push_back(seen_byte && (pattern_at(pat_pos) == NUL_CHAR));
				clear_name();
				return;
			end
			limit = (max_len == '0) ? 8'd1 : max_len;
			if (name_pos >= limit) begin
				bytes_skipped++;
				return;
			end
			bytes_taken++;
			// One star consumed per byte, it sets the resume point
			c = pattern_at(pat_pos);
			if (c == STAR_CHAR) begin
				pat_pos  = bump(pat_pos);
				star_pos = pat_pos;
				c        = pattern_at(pat_pos);
			end
			nb = b;
			if (!case_sens) begin
				c  = c & FOLD_MASK;
				nb = nb & FOLD_MASK;
			end
			// Mismatch falls back without retrying the byte
			if (c == nb)
				pat_pos = bump(pat_pos);
			else
				pat_pos = star_pos;
			seen_byte = 1'b1;
			if (name_pos != NAME_POS_MAX)
				name_pos++;
		endfunction

		function void check_result(logic m);
			logic want;
			if (expected_matches.size() == 0) begin
				errors++;
				$display("%0t: result with none pending: expected none, actual %0b", $time, m);
				return;
			end
			want = expected_matches.pop_front();
			results_checked++;
			if (m !== want) begin
				errors++;
				$display("%0t: matched mismatch: expected %0b, actual %0b", $time, want, m);
			end else if (m) begin
				matches_seen++;
			end
		endfunction

		function int pending();
			return expected_matches.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             name_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic                   matched;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	match_scoreboard sb = new();

	int in_idle_pct;
	int out_idle_pct;
	bit hold_request;
	int idle_cycles;
	int items_sent;
	int names_sent;

	wildcard_name_matcher_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.name_byte (name_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Monitor: values seen here are the ones present before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(name_byte);
			if (out_valid && out_ready)
				sb.check_result(matched);
		end
	end

	// Cycles without any transaction or register write
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_wildcard_name_matcher_top: FAIL");
		$finish;
	end

	// Result side: random stalls, plus one long hold on request
	initial begin : result_sink
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
		end
	end

	// Offer one byte and wait for it to be taken
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		name_byte <= b;
		items_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_name(byte_q_t body);
		foreach (body[i])
			send_byte(body[i]);
		send_byte(NUL_CHAR);
		names_sent++;
	endtask

	// Wait for all results, then let the last byte clear the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		// Let the monitor note the last transaction first
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on back-to-back cycles; block must be idle
	task automatic load_config(logic [127:0] pat, logic cs, logic [7:0] max_len);
		logic [CFG_DATA_W-1:0] vals[4];
		vals[REG_PATTERN_LOW]  = pat[63:0];
		vals[REG_PATTERN_HIGH] = pat[127:64];
		// Unused upper bits carry noise
		vals[REG_CASE_SENS]    = {$urandom, $urandom};
		vals[REG_CASE_SENS][0] = cs;
		vals[REG_MAX_LEN]      = {$urandom, $urandom};
		vals[REG_MAX_LEN][7:0] = max_len;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic byte_q_t str_bytes(string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [127:0] str_pattern(string s);
		logic [127:0] p;
		p = '0;
		for (int i = 0; i < s.len() && i < STORE_BYTES; i++)
			p[8*i +: 8] = s[i];
		return p;
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(0, 4));
		if ($urandom_range(0, 1))
			c = c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] rand_pattern_char();
		case ($urandom_range(0, 9))
			0, 1:    return STAR_CHAR;
			2:       return 8'h20;
			3:       return 8'($urandom_range(1, 255));
			default: return rand_letter();
		endcase
	endfunction

	// Random pattern, sometimes with junk past the terminator
	function automatic logic [127:0] rand_pattern();
		logic [127:0] p;
		int           n;
		bit           junk;
		p    = '0;
		n    = $urandom_range(0, STORE_BYTES);
		junk = $urandom_range(0, 1);
		for (int i = 0; i < STORE_BYTES; i++) begin
			if (i < n)
				p[8*i +: 8] = rand_pattern_char();
			else if (i > n && junk)
				p[8*i +: 8] = 8'($urandom_range(0, 255));
		end
		return p;
	endfunction

	// Name built to fit the pattern, with an occasional defect
	function automatic byte_q_t name_for(logic [127:0] p);
		byte_q_t    q;
		logic [7:0] c;
		int         pos;
		for (int i = 0; i < STORE_BYTES; i++) begin
			c = p[8*i +: 8];
			if (c == NUL_CHAR)
				break;
			if (c == STAR_CHAR) begin
				repeat ($urandom_range(0, 3))
					q.push_back(rand_letter());
			end else begin
				if ($urandom_range(0, 3) == 0 && (c ^ 8'h20) != NUL_CHAR)
					c = c ^ 8'h20;
				q.push_back(c);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					if (q.size() > 0) begin
						pos    = $urandom_range(0, q.size() - 1);
						q[pos] = 8'($urandom_range(1, 255));
					end
				end
				1: q.push_back(rand_letter());
				default: begin
					if (q.size() > 0)
						void'(q.pop_back());
				end
			endcase
		end
		return q;
	endfunction

	function automatic byte_q_t noise_name();
		byte_q_t q;
		repeat ($urandom_range(0, 10))
			q.push_back(8'($urandom_range(1, 255)));
		return q;
	endfunction

	initial begin : stimulus
		logic [127:0] pat;
		logic [7:0]   max_len;
		logic         cs;
		byte_q_t      body;
		int           phase;
		int           target;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		name_byte    = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hold_request = 1'b0;
		idle_cycles  = 0;
		items_sent   = 0;
		names_sent   = 0;
		in_idle_pct  = 27;
		out_idle_pct = 46;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty name, and a space that folds onto the terminator
		send_name(str_bytes(""));
		send_name(str_bytes(" "));
		settle();

		// Star with folding, then raw compare
		load_config(str_pattern("a*C"), 1'b0, 8'd255);
		send_name(str_bytes("AxyC"));
		send_name(str_bytes("ab"));
		settle();
		load_config(str_pattern("a*C"), 1'b1, 8'd255);
		send_name(str_bytes("axC"));
		send_name(str_bytes("AxC"));
		settle();

		// Full store with no terminator, zero limit acting as one
		load_config('1, 1'b1, 8'd0);
		body = '{8'hFF, 8'hFF};
		send_name(body);
		settle();

		// Random phases; idle pattern changes by thirds
		target = items_sent + RANDOM_ITEMS;
		phase  = 0;
		while (items_sent < target) begin
			if (items_sent < target - (2 * RANDOM_ITEMS) / 3) begin
				in_idle_pct  = 27;
				out_idle_pct = 46;
			end else if (items_sent < target - RANDOM_ITEMS / 3) begin
				in_idle_pct  = 46;
				out_idle_pct = 27;
			end else begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end

			case ($urandom_range(0, 9))
				0:       pat = '1;
				1:       pat = '0;
				default: pat = rand_pattern();
			endcase
			cs = $urandom_range(0, 1);
			case ($urandom_range(0, 7))
				0:       max_len = 8'd0;
				1:       max_len = 8'd1;
				2, 3:    max_len = 8'($urandom_range(2, 12));
				4:       max_len = 8'($urandom_range(0, 255));
				default: max_len = 8'd255;
			endcase
			if (phase == 4)
				max_len = 8'd255;
			load_config(pat, cs, max_len);

			// Long result stall so the block backs up into the input
			if (phase == 2)
				hold_request = 1'b1;

			// One name long enough to run into the length limit
			if (phase == 4) begin
				body = {};
				repeat (260)
					body.push_back(rand_letter());
				send_name(body);
			end

			repeat ($urandom_range(8, 16)) begin
				if ($urandom_range(0, 3) == 0)
					send_name(noise_name());
				else
					send_name(name_for(pat));
			end
			settle();
			phase++;
		end

		$display("Sent %0d names in %0d bytes over %0d register settings.",
			names_sent, items_sent, sb.cfg_writes / 4);
		$display("Checked %0d results (%0d matches); %0d bytes fell past the length limit.",
			sb.results_checked, sb.matches_seen, sb.bytes_skipped);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_wildcard_name_matcher_top: PASS");
		else
			$display("tb_wildcard_name_matcher_top: FAIL");
		$finish;
	end

endmodule
